// ===== rtl/core/step_sine_square_waveform_source_defines.svh =====
// ----------------------------------------------------------------------------
// step_sine_square_waveform_source_defines
// Assertion macros for the waveform source modules, used by sswf_phase
// ----------------------------------------------------------------------------
`ifndef STEP_SINE_SQUARE_WAVEFORM_SOURCE_DEFINES_SVH
`define STEP_SINE_SQUARE_WAVEFORM_SOURCE_DEFINES_SVH

// same-cycle implication, clocked on clk, off while arst_n is low
`define SSWF_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, clocked on clk, off while arst_n is low
`define SSWF_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== rtl/core/sswf_pkg.sv =====
// ----------------------------------------------------------------------------
// sswf_pkg
// Register map, mode codes and sine table generator for the waveform source
// ----------------------------------------------------------------------------
package sswf_pkg;

	localparam int REG_ADDR_W = 3;
	localparam int CFG_DATA_W = 32;
	localparam int TICK_W     = 32;
	localparam int VALUE_W    = 16;

	localparam logic [REG_ADDR_W-1:0] REG_WAVE_MODE       = 3'd0;
	localparam logic [REG_ADDR_W-1:0] REG_AMPLITUDE       = 3'd1;
	localparam logic [REG_ADDR_W-1:0] REG_OFFSET          = 3'd2;
	localparam logic [REG_ADDR_W-1:0] REG_STEP_TICKS      = 3'd3;
	localparam logic [REG_ADDR_W-1:0] REG_PHASE_INCREMENT = 3'd4;

	localparam logic [1:0] MODE_STEP   = 2'd0;
	localparam logic [1:0] MODE_SINE   = 2'd1;
	localparam logic [1:0] MODE_SQUARE = 2'd2;

	localparam logic [1:0]         RST_WAVE_MODE       = MODE_STEP;
	localparam logic [VALUE_W-1:0] RST_AMPLITUDE       = 16'd819;
	localparam logic [VALUE_W-1:0] RST_OFFSET          = 16'd0;
	localparam logic [TICK_W-1:0]  RST_STEP_TICKS      = 32'd50;
	localparam logic [31:0]        RST_PHASE_INCREMENT = 32'd21474836;

	localparam logic [TICK_W-1:0] TICK_MAX = '1;

	localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;
	localparam logic [63:0] ONE_Q30     = 64'd1 << 30;

	typedef struct packed {
		logic [1:0]                wave_mode;
		logic signed [VALUE_W-1:0] amplitude;
		logic signed [VALUE_W-1:0] offset;
		logic [TICK_W-1:0]         step_ticks;
		logic [31:0]               phase_increment;
	} cfg_t;

	// quarter-wave entry k: round(sin((2k+1)*pi/(4*2^addr_bits)) * (2^(sample_bits-1)-1))
	// sin from a degree-15 taylor series in q30, horner form, truncating steps
	function automatic logic [31:0] qtab_entry(input int unsigned k,
			input int unsigned addr_bits, input int unsigned sample_bits);
		logic [63:0] x;
		logic [63:0] x2;
		logic [63:0] t;
		logic [63:0] s;
		logic [63:0] maxv;
		maxv = (64'd1 << (sample_bits - 1)) - 64'd1;
		x    = ((64'd2 * 64'(k) + 64'd1) * HALF_PI_Q30) >> (addr_bits + 1);
		x2   = (x * x) >> 30;
		t    = ONE_Q30;
		t    = ONE_Q30 - (((x2 * t) >> 30) / 64'd210);
		t    = ONE_Q30 - (((x2 * t) >> 30) / 64'd156);
		t    = ONE_Q30 - (((x2 * t) >> 30) / 64'd110);
		t    = ONE_Q30 - (((x2 * t) >> 30) / 64'd72);
		t    = ONE_Q30 - (((x2 * t) >> 30) / 64'd42);
		t    = ONE_Q30 - (((x2 * t) >> 30) / 64'd20);
		t    = ONE_Q30 - (((x2 * t) >> 30) / 64'd6);
		s    = (x * t) >> 30;
		return 32'((s * maxv + (ONE_Q30 >> 1)) >> 30);
	endfunction

endpackage

// ===== rtl/core/sswf_cfg_regs.sv =====
// ----------------------------------------------------------------------------
// sswf_cfg_regs
// Configuration register file, write only
// ----------------------------------------------------------------------------
module sswf_cfg_regs import sswf_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_we,
	input  logic [REG_ADDR_W-1:0] cfg_addr,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	output cfg_t                  cfg
);

	cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.wave_mode       <= RST_WAVE_MODE;
			cfg_q.amplitude       <= RST_AMPLITUDE;
			cfg_q.offset          <= RST_OFFSET;
			cfg_q.step_ticks      <= RST_STEP_TICKS;
			cfg_q.phase_increment <= RST_PHASE_INCREMENT;
		end else if (cfg_we) begin
			case (cfg_addr)
				REG_WAVE_MODE:       cfg_q.wave_mode       <= cfg_data[1:0];
				REG_AMPLITUDE:       cfg_q.amplitude       <= cfg_data[VALUE_W-1:0];
				REG_OFFSET:          cfg_q.offset          <= cfg_data[VALUE_W-1:0];
				REG_STEP_TICKS:      cfg_q.step_ticks      <= cfg_data[TICK_W-1:0];
				REG_PHASE_INCREMENT: cfg_q.phase_increment <= cfg_data[31:0];
				default: ;
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

// ===== rtl/core/sswf_phase.sv =====
// ----------------------------------------------------------------------------
// sswf_phase
// Tick intake: saturating elapsed-tick counter and phase accumulator
// ----------------------------------------------------------------------------
module sswf_phase import sswf_pkg::*; #(
	parameter int PHASE_BITS = 32
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  s_tvalid,
	output logic                  s_tready,
	input  logic                  restart,
	input  logic [31:0]           phase_increment,
	output logic                  valid_s1,
	input  logic                  ready_s1,
	output logic [TICK_W-1:0]     elapsed_q,
	output logic [PHASE_BITS-1:0] phase_q
);

	`include "step_sine_square_waveform_source_defines.svh"

	logic                      accept;
	logic [TICK_W-1:0]         elapsed_base;
	logic [TICK_W-1:0]         elapsed_nxt;
	logic [PHASE_BITS-1:0]     phase_base;
	logic [PHASE_BITS-1:0]     phase_inc;
	logic [PHASE_BITS+31:0]    inc_wide;

	assign s_tready = !valid_s1 || ready_s1;
	assign accept   = s_tvalid && s_tready;

	// increment masked or zero-extended to the accumulator width
	assign inc_wide  = {{PHASE_BITS{1'b0}}, phase_increment};
	assign phase_inc = inc_wide[PHASE_BITS-1:0];

	assign elapsed_base = restart ? '0 : elapsed_q;
	assign elapsed_nxt  = (elapsed_base == TICK_MAX) ? elapsed_base : elapsed_base + 1'b1;
	assign phase_base   = restart ? '0 : phase_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1  <= 1'b0;
			elapsed_q <= '0;
			phase_q   <= '0;
		end else begin
			if (accept) begin
				valid_s1  <= 1'b1;
				elapsed_q <= elapsed_nxt;
				phase_q   <= phase_base + phase_inc;
			end else if (ready_s1) begin
				valid_s1  <= 1'b0;
			end
		end
	end

	`SSWF_ASSERT_NEXT(a_restart_count, accept && restart, elapsed_q == TICK_W'(1), "restart tick must see elapsed count of one")
	`SSWF_ASSERT_NEXT(a_count_step, accept && !restart && elapsed_q != TICK_MAX, elapsed_q == $past(elapsed_q) + 1'b1, "elapsed count must advance by one per tick")
	`SSWF_ASSERT_NEXT(a_state_hold, !accept, $stable(elapsed_q) && $stable(phase_q), "time state moved without a tick")

endmodule

// ===== rtl/core/sswf_wave.sv =====
// ----------------------------------------------------------------------------
// sswf_wave
// Quarter-wave sine lookup and amplitude multiply, step and square selection
// ----------------------------------------------------------------------------
module sswf_wave import sswf_pkg::*; #(
	parameter int PHASE_BITS      = 32,
	parameter int TABLE_ADDR_BITS = 8,
	parameter int SAMPLE_BITS     = 16
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  cfg_t                       cfg,
	input  logic                       valid_s1,
	output logic                       ready_s1,
	input  logic [TICK_W-1:0]          elapsed_q,
	input  logic [PHASE_BITS-1:0]      phase_q,
	output logic                       valid_s2,
	input  logic                       ready_s2,
	output logic                       is_sine_s2,
	output logic                       neg_s2,
	output logic [SAMPLE_BITS+15:0]    prod_s2,
	output logic signed [VALUE_W:0]    addend_s2
);

	localparam int TBL_LEN = 1 << TABLE_ADDR_BITS;
	localparam int SMAG_W  = SAMPLE_BITS - 1;
	localparam int PROD_W  = SAMPLE_BITS + 16;

	logic [SMAG_W-1:0]          qtable [TBL_LEN];
	logic [1:0]                 quad;
	logic [TABLE_ADDR_BITS-1:0] raw_idx;
	logic [TABLE_ADDR_BITS-1:0] idx;
	logic [SMAG_W-1:0]          smag;
	logic signed [VALUE_W:0]    amp_ext;
	logic [VALUE_W:0]           amp_mag;
	logic [PROD_W-1:0]          prod;
	logic                       is_sine;
	logic signed [VALUE_W:0]    addend;

	for (genvar k = 0; k < TBL_LEN; k++) begin : g_tbl
		assign qtable[k] = SMAG_W'(qtab_entry(k, TABLE_ADDR_BITS, SAMPLE_BITS));
	end

	assign quad    = phase_q[PHASE_BITS-1 -: 2];
	assign raw_idx = phase_q[PHASE_BITS-3 -: TABLE_ADDR_BITS];
	// odd quadrants run the table backward
	assign idx     = quad[0] ? ~raw_idx : raw_idx;
	assign smag    = qtable[idx];

	assign amp_ext = {cfg.amplitude[VALUE_W-1], cfg.amplitude};
	assign amp_mag = amp_ext[VALUE_W] ? -amp_ext : amp_ext;
	assign prod    = PROD_W'(amp_mag) * PROD_W'(smag);

	always_comb begin
		is_sine = 1'b0;
		case (cfg.wave_mode)
			MODE_STEP: addend = (elapsed_q >= cfg.step_ticks) ? amp_ext : '0;
			MODE_SINE: begin
				is_sine = 1'b1;
				addend  = '0;
			end
			default: addend = phase_q[PHASE_BITS-1] ? -amp_ext : amp_ext;
		endcase
	end

	assign ready_s1 = !valid_s2 || ready_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (ready_s1) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (valid_s1 && ready_s1) begin
			is_sine_s2 <= is_sine;
			neg_s2     <= quad[1] ^ cfg.amplitude[VALUE_W-1];
			prod_s2    <= prod;
			addend_s2  <= addend;
		end
	end

endmodule

// ===== rtl/core/sswf_out.sv =====
// ----------------------------------------------------------------------------
// sswf_out
// Product rounding, offset add, 16-bit saturation and result register
// ----------------------------------------------------------------------------
module sswf_out import sswf_pkg::*; #(
	parameter int SAMPLE_BITS = 16
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic signed [VALUE_W-1:0] offset,
	input  logic                      valid_s2,
	output logic                      ready_s2,
	input  logic                      is_sine_s2,
	input  logic                      neg_s2,
	input  logic [SAMPLE_BITS+15:0]   prod_s2,
	input  logic signed [VALUE_W:0]   addend_s2,
	output logic                      m_tvalid,
	input  logic                      m_tready,
	output logic [VALUE_W-1:0]        m_tdata
);

	localparam int RND_W = SAMPLE_BITS + 17;
	localparam int SUM_W = VALUE_W + 3;

	logic [RND_W-1:0]          rnd;
	logic [VALUE_W:0]          rmag;
	logic signed [VALUE_W+1:0] rterm;
	logic signed [VALUE_W+1:0] term;
	logic signed [SUM_W-1:0]   sum;
	logic [VALUE_W-1:0]        sat;
	logic [VALUE_W-1:0]        value_q;

	// round half away from zero on the magnitude
	assign rnd   = {1'b0, prod_s2} + (RND_W'(1) << (SAMPLE_BITS - 2));
	assign rmag  = rnd[SAMPLE_BITS-1 +: VALUE_W+1];
	assign rterm = neg_s2 ? -$signed({1'b0, rmag}) : $signed({1'b0, rmag});
	assign term  = is_sine_s2 ? rterm : {addend_s2[VALUE_W], addend_s2};
	assign sum   = SUM_W'(offset) + SUM_W'(term);

	always_comb begin
		if (sum > SUM_W'(32767)) begin
			sat = {1'b0, {(VALUE_W-1){1'b1}}};
		end else if (sum < -SUM_W'(32768)) begin
			sat = {1'b1, {(VALUE_W-1){1'b0}}};
		end else begin
			sat = sum[VALUE_W-1:0];
		end
	end

	assign ready_s2 = !m_tvalid || m_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid <= 1'b0;
		end else if (ready_s2) begin
			m_tvalid <= valid_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (valid_s2 && ready_s2) begin
			value_q <= sat;
		end
	end

	assign m_tdata = value_q;

endmodule

// ===== rtl/core/step_sine_square_waveform_source.sv =====
// path: an accepted tick is registered in the phase stage, then the wave stage, then the result register on m_tdata
// throughput: one tick per cycle; each stage holds only while the one after it is full
// stages: phase/tick counter, sine lookup and multiply, round/offset/saturate
// reset: arst_n clears elapsed ticks, phase and all valid flags, and loads the
// register defaults (step mode, amplitude 819, step at 50 ticks)
// ----------------------------------------------------------------------------
// step_sine_square_waveform_source
// Tick-driven step, sine or square command source with a phase accumulator
// ----------------------------------------------------------------------------
module step_sine_square_waveform_source import sswf_pkg::*; #(
	parameter int PHASE_BITS      = 32,
	parameter int TABLE_ADDR_BITS = 8,
	parameter int SAMPLE_BITS     = 16
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  s_tvalid,
	output logic                  s_tready,
	input  logic [7:0]            s_tdata,   // [0] restart, [7:1] zero
	output logic                  m_tvalid,
	input  logic                  m_tready,
	output logic [VALUE_W-1:0]    m_tdata,   // [15:0] torque_value
	input  logic                  cfg_we,
	input  logic [REG_ADDR_W-1:0] cfg_addr,
	input  logic [CFG_DATA_W-1:0] cfg_data
);

	cfg_t                    cfg;
	logic                    valid_s1;
	logic                    ready_s1;
	logic [TICK_W-1:0]       elapsed_q;
	logic [PHASE_BITS-1:0]   phase_q;
	logic                    valid_s2;
	logic                    ready_s2;
	logic                    is_sine_s2;
	logic                    neg_s2;
	logic [SAMPLE_BITS+15:0] prod_s2;
	logic signed [VALUE_W:0] addend_s2;

	sswf_cfg_regs u_cfg (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_we   (cfg_we),
		.cfg_addr (cfg_addr),
		.cfg_data (cfg_data),
		.cfg      (cfg)
	);

	sswf_phase #(
		.PHASE_BITS (PHASE_BITS)
	) u_phase (
		.clk             (clk),
		.arst_n          (arst_n),
		.s_tvalid        (s_tvalid),
		.s_tready        (s_tready),
		.restart         (s_tdata[0]),
		.phase_increment (cfg.phase_increment),
		.valid_s1        (valid_s1),
		.ready_s1        (ready_s1),
		.elapsed_q       (elapsed_q),
		.phase_q         (phase_q)
	);

	sswf_wave #(
		.PHASE_BITS      (PHASE_BITS),
		.TABLE_ADDR_BITS (TABLE_ADDR_BITS),
		.SAMPLE_BITS     (SAMPLE_BITS)
	) u_wave (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg        (cfg),
		.valid_s1   (valid_s1),
		.ready_s1   (ready_s1),
		.elapsed_q  (elapsed_q),
		.phase_q    (phase_q),
		.valid_s2   (valid_s2),
		.ready_s2   (ready_s2),
		.is_sine_s2 (is_sine_s2),
		.neg_s2     (neg_s2),
		.prod_s2    (prod_s2),
		.addend_s2  (addend_s2)
	);

	sswf_out #(
		.SAMPLE_BITS (SAMPLE_BITS)
	) u_out (
		.clk        (clk),
		.arst_n     (arst_n),
		.offset     (cfg.offset),
		.valid_s2   (valid_s2),
		.ready_s2   (ready_s2),
		.is_sine_s2 (is_sine_s2),
		.neg_s2     (neg_s2),
		.prod_s2    (prod_s2),
		.addend_s2  (addend_s2),
		.m_tvalid   (m_tvalid),
		.m_tready   (m_tready),
		.m_tdata    (m_tdata)
	);

endmodule

// ===== verif/step_sine_square_waveform_source_tb.sv =====
// ----------------------------------------------------------------------------
// step_sine_square_waveform_source_tb
// Self-checking bench: ticks go in on the slave stream, command values come
// back on the master stream and are compared against a cycle-free predictor
// of the step, sine and square generator under changing register settings
// ----------------------------------------------------------------------------
module step_sine_square_waveform_source_tb;
	timeunit 1ns;
	timeprecision 1ps;
	import sswf_pkg::*;

	localparam logic [1:0] MODE_UNUSED = 2'd3;
	localparam int CYCLE_LIMIT = 200_000;
	localparam int PRINT_CAP   = 200;

	// predicts the torque value of every accepted tick and holds the values due
	class torque_tracker;
		cfg_t        regs;
		logic [31:0] ticks_seen;
		logic [31:0] phase;
		logic [15:0] quarter_sine [256];
		logic [15:0] expected_torque [$];
		int          mismatches;

		function new();
			longint unsigned x;
			longint unsigned x2;
			longint unsigned t;
			longint unsigned s;
			longint unsigned unity;
			unity = 64'd1 << 30;
			// sin in q30 over a quarter turn, taylor series to degree 15
			for (int k = 0; k < 256; k++) begin
				x  = ((2 * longint'(k) + 1) * 64'd1686629713) / 64'd512;
				x2 = (x * x) >> 30;
				t  = unity;
				for (int n = 7; n >= 1; n--) begin
					t = unity - ((x2 * t) >> 30) / longint'((2 * n) * (2 * n + 1));
				end
				s = (x * t) >> 30;
				quarter_sine[k] = 16'((s * 64'd32767 + (unity >> 1)) >> 30);
			end
			regs.wave_mode       = MODE_STEP;
			regs.amplitude       = 16'd819;
			regs.offset          = 16'd0;
			regs.step_ticks      = 32'd50;
			regs.phase_increment = 32'd21474836;
			ticks_seen = '0;
			phase      = '0;
			mismatches = 0;
		endfunction

		function void write_reg(logic [REG_ADDR_W-1:0] addr, logic [CFG_DATA_W-1:0] data);
			case (addr)
				REG_WAVE_MODE:       regs.wave_mode       = data[1:0];
				REG_AMPLITUDE:       regs.amplitude       = data[15:0];
				REG_OFFSET:          regs.offset          = data[15:0];
				REG_STEP_TICKS:      regs.step_ticks      = data[31:0];
				REG_PHASE_INCREMENT: regs.phase_increment = data[31:0];
				default: ;
			endcase
		endfunction

		function void tick_accepted(logic restart);
			longint     amp;
			longint     sum;
			longint     mag;
			longint     rounded;
			logic [1:0] quad;
			logic [7:0] idx;
			amp = $signed(regs.amplitude);
			sum = $signed(regs.offset);
			if (restart) begin
				ticks_seen = '0;
				phase      = '0;
			end
			// the tick counts before the value is formed
			if (ticks_seen != '1)
				ticks_seen++;
			phase += regs.phase_increment;
			case (regs.wave_mode)
				MODE_STEP: begin
					if (ticks_seen >= regs.step_ticks)
						sum += amp;
				end
				MODE_SINE: begin
					quad = phase[31:30];
					// odd quadrants read the table backwards
					idx  = quad[0] ? ~phase[29:22] : phase[29:22];
					mag  = quarter_sine[idx];
					rounded = ((amp < 0 ? -amp : amp) * mag + 16384) >> 15;
					sum += ((amp < 0) != quad[1]) ? -rounded : rounded;
				end
				// square, and the unused code behaves the same
				default: sum += phase[31] ? -amp : amp;
			endcase
			if (sum > 32767)
				sum = 32767;
			else if (sum < -32768)
				sum = -32768;
			expected_torque.push_back(sum[15:0]);
		endfunction

		function void value_out(logic [15:0] got);
			logic [15:0] want;
			if (expected_torque.size() == 0) begin
				mismatches++;
				if (mismatches <= PRINT_CAP)
					$display("%0t: torque value %0d with no tick transaction pending",
						$time, $signed(got));
			end else begin
				want = expected_torque.pop_front();
				if (got !== want) begin
					mismatches++;
					if (mismatches <= PRINT_CAP)
						$display("%0t: torque value expected %0d, actual %0d",
							$time, $signed(want), $signed(got));
				end
			end
		endfunction
	endclass

	logic                  clk      = 1'b0;
	logic                  arst_n   = 1'b0;
	logic                  s_tvalid = 1'b0;
	logic                  s_tready;
	logic [7:0]            s_tdata  = '0;   // [0] restart, [7:1] zero
	logic                  m_tvalid;
	logic                  m_tready = 1'b0;
	logic [VALUE_W-1:0]    m_tdata;         // [15:0] torque_value
	logic                  cfg_we   = 1'b0;
	logic [REG_ADDR_W-1:0] cfg_addr = '0;
	logic [CFG_DATA_W-1:0] cfg_data = '0;

	torque_tracker tracker;
	int            gap_pct   = 0;
	int            stall_pct = 0;
	int            cycles    = 0;

	step_sine_square_waveform_source DUT (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.cfg_we   (cfg_we),
		.cfg_addr (cfg_addr),
		.cfg_data (cfg_data)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles >= CYCLE_LIMIT) begin
			$display("step_sine_square_waveform_source regression: fail");
			$finish;
		end
	end

	always @(posedge clk) begin
		m_tready <= ($urandom_range(0, 99) >= stall_pct);
	end

	// check the output before noting the input, so a stray value is caught
	always @(posedge clk) begin
		if (arst_n) begin
			if (m_tvalid && m_tready)
				tracker.value_out(m_tdata);
			if (s_tvalid && s_tready)
				tracker.tick_accepted(s_tdata[0]);
		end
	end

	// tasks are entered and left just after a rising edge
	task automatic send_tick(input logic restart);
		while ($urandom_range(0, 99) < gap_pct) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= {7'd0, restart};
		@(posedge clk);
		while (!s_tready)
			@(posedge clk);
	endtask

	task automatic drain();
		s_tvalid <= 1'b0;
		@(posedge clk);
		while (tracker.expected_torque.size() != 0)
			@(posedge clk);
		// pipeline is three stages deep
		repeat (4) @(posedge clk);
	endtask

	task automatic write_reg(input logic [REG_ADDR_W-1:0] addr,
			input logic [CFG_DATA_W-1:0] data);
		cfg_we   <= 1'b1;
		cfg_addr <= addr;
		cfg_data <= data;
		tracker.write_reg(addr, data);
		@(posedge clk);
	endtask

	task automatic load_config(input logic [1:0] mode, input logic [15:0] amp,
			input logic [15:0] off, input logic [31:0] step_at, input logic [31:0] inc);
		drain();
		write_reg(REG_WAVE_MODE, {30'd0, mode});
		write_reg(REG_AMPLITUDE, {16'd0, amp});
		write_reg(REG_OFFSET, {16'd0, off});
		write_reg(REG_STEP_TICKS, step_at);
		write_reg(REG_PHASE_INCREMENT, inc);
		cfg_we <= 1'b0;
	endtask

	initial begin
		logic [1:0]  mode;
		logic [15:0] amp;
		logic [15:0] off;
		logic [31:0] step_at;
		logic [31:0] inc;
		int          pick;
		int          n;
		int          total;
		int          phase_no;
		tracker = new();
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// register defaults straight out of reset
		send_tick(1'b1);
		send_tick(1'b0);
		send_tick(1'b0);
		// both saturation limits, step on the first tick after restart
		load_config(MODE_STEP, 16'h7FFF, 16'h7FFF, 32'd1, 32'd0);
		send_tick(1'b1);
		send_tick(1'b0);
		load_config(MODE_STEP, 16'h8000, 16'h8000, 32'd0, 32'hFFFF_FFFF);
		send_tick(1'b1);
		send_tick(1'b0);
		// step that never switches on
		load_config(MODE_STEP, 16'd819, 16'd0, 32'hFFFF_FFFF, 32'd0);
		send_tick(1'b0);
		send_tick(1'b0);
		// sine through all four quadrants, then a step of one table entry per tick
		load_config(MODE_SINE, 16'h7FFF, 16'd0, 32'd0, 32'h4000_0000);
		send_tick(1'b1);
		send_tick(1'b0);
		send_tick(1'b0);
		send_tick(1'b0);
		load_config(MODE_SINE, 16'h8000, 16'd100, 32'd0, 32'h0040_0000);
		send_tick(1'b1);
		send_tick(1'b0);
		// square landing on phase zero, and the unused mode code
		load_config(MODE_SQUARE, 16'h8000, 16'd0, 32'd0, 32'h8000_0000);
		send_tick(1'b1);
		send_tick(1'b0);
		send_tick(1'b0);
		load_config(MODE_UNUSED, 16'd12345, -16'sd1000, 32'd0, 32'hFFFF_FFFF);
		send_tick(1'b1);
		send_tick(1'b0);

		total    = 0;
		phase_no = 0;
		while (total < 1900) begin
			case (phase_no % 4)
				0: begin
					gap_pct   = 0;
					stall_pct = 0;
				end
				1: begin
					gap_pct   = 53;
					stall_pct = 0;
				end
				2: begin
					gap_pct   = 0;
					stall_pct = 53;
				end
				default: begin
					gap_pct   = 28;
					stall_pct = 28;
				end
			endcase

			pick = $urandom_range(0, 9);
			mode = (pick < 3) ? MODE_STEP : (pick < 6) ? MODE_SINE :
				(pick < 9) ? MODE_SQUARE : MODE_UNUSED;
			case ($urandom_range(0, 3))
				0: amp = $urandom_range(0, 1) ? 16'h7FFF : 16'h8000;
				1: amp = 16'($urandom_range(0, 4095) - 2048);
				default: amp = 16'($urandom());
			endcase
			case ($urandom_range(0, 3))
				0: off = 16'd0;
				1: off = $urandom_range(0, 1) ? 16'h7FFF : 16'h8000;
				2: off = 16'($urandom());
				default: off = 16'($urandom_range(0, 8191) - 4096);
			endcase
			case ($urandom_range(0, 3))
				0: step_at = $urandom_range(0, 1) ? 32'd0 : 32'hFFFF_FFFF;
				1: step_at = $urandom();
				default: step_at = $urandom_range(0, 200);
			endcase
			case ($urandom_range(0, 3))
				0: inc = $urandom();
				1: inc = $urandom_range(0, 1 << 24);
				2: inc = 32'd1 << $urandom_range(0, 31);
				default: begin
					pick = $urandom_range(0, 2);
					inc = (pick == 0) ? 32'd0 : (pick == 1) ? 32'hFFFF_FFFF : 32'h8000_0000;
				end
			endcase
			load_config(mode, amp, off, step_at, inc);

			n = $urandom_range(40, 160);
			send_tick($urandom_range(0, 1) == 0);
			repeat (n - 1) send_tick($urandom_range(0, 39) == 0);
			total += n;
			phase_no++;
		end

		s_tvalid <= 1'b0;
		while (tracker.expected_torque.size() != 0)
			@(posedge clk);
		repeat (8) @(posedge clk);
		if (tracker.mismatches == 0) begin
			$display("step_sine_square_waveform_source regression: pass");
		end else begin
			$display("step_sine_square_waveform_source regression: fail");
		end
		$finish;
	end

endmodule
